@@ rtl/bsd_pkg.sv @@
// bsd_pkg: shared types and constants for the bend segment detector
// no dependencies; imported by bsd_step, bend_segment_detector and bsd_checker
package bsd_pkg;

   localparam logic [7:0] CentreAngle    = 8'd90;
   localparam logic [6:0] ThresholdReset = 7'd10;

   // one steering sample
   typedef struct packed {
      logic [15:0] position;
      logic [7:0]  angle;
   } req_type;

   // one closed-bend record
   typedef struct packed {
      logic [7:0]  bend_index;
      logic        bend_kind;
      logic [7:0]  peak_angle;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic [15:0] start_edge_pos;
      logic [15:0] end_edge_pos;
   } rsp_type;

   // tracking state carried from sample to sample
   typedef struct packed {
      logic [7:0]  prev_angle;
      logic        prev_falling;
      logic        prev_below_centre;
      logic        in_bend;
      logic [15:0] edge_out_pos;
      logic [15:0] edge_in_pos;
      logic [15:0] last_turn_pos;
      logic [15:0] open_start_pos;
      logic [15:0] open_start_edge;
      logic        open_kind;
      logic [7:0]  open_peak;
      logic [7:0]  bend_count;
   } state_type;

   localparam state_type StateReset = '{
      prev_angle:        CentreAngle,
      prev_falling:      1'b1,
      prev_below_centre: 1'b0,
      in_bend:           1'b0,
      edge_out_pos:      16'd0,
      edge_in_pos:       16'd0,
      last_turn_pos:     16'd0,
      open_start_pos:    16'd0,
      open_start_edge:   16'd0,
      open_kind:         1'b0,
      open_peak:         8'd0,
      bend_count:        8'd0
   };

endpackage

@@ rtl/bsd_step.sv @@
// bsd_step: combinational next-state and record logic for one sample
// depends on bsd_pkg
module bsd_step
   import bsd_pkg::*;
(
   input  state_type  cur_state,
   input  req_type    sample,
   input  logic [6:0] band_threshold,
   output state_type  nxt_state,
   output logic       emit,
   output rsp_type    record
);

   logic              falling;
   logic              below;
   logic              turn;
   logic signed [9:0] a;
   logic signed [9:0] p;
   logic signed [9:0] hi;
   logic signed [9:0] lo;
   logic              above_hi;
   logic              below_lo;

   assign a  = signed'({2'b00, sample.angle});
   assign p  = signed'({2'b00, cur_state.prev_angle});
   assign hi = signed'({2'b00, CentreAngle}) + signed'({3'b000, band_threshold});
   assign lo = signed'({2'b00, CentreAngle}) - signed'({3'b000, band_threshold});

   assign above_hi = a > hi;
   assign below_lo = a < lo;

   always_comb begin
      if (sample.angle < cur_state.prev_angle) begin
         falling = 1'b1;
      end else if (sample.angle > cur_state.prev_angle) begin
         falling = 1'b0;
      end else begin
         falling = cur_state.prev_falling;
      end
      below = sample.angle < CentreAngle;
      turn  = (below != cur_state.prev_below_centre) || (falling != cur_state.prev_falling);
   end

   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;

      // band edge crossings, seen by the turning-point logic below
      if (!cur_state.in_bend) begin
         if ((p < hi && a >= hi) || (p > lo && a <= lo)) begin
            nxt_state.edge_out_pos = sample.position;
         end
      end else begin
         if ((p > hi && a <= hi) || (p < lo && a >= lo)) begin
            nxt_state.edge_in_pos = sample.position;
         end
      end

      if (turn) begin
         if (!cur_state.in_bend) begin
            if (above_hi || below_lo) begin
               nxt_state.in_bend         = 1'b1;
               nxt_state.open_kind       = above_hi;
               nxt_state.open_peak       = sample.angle;
               nxt_state.open_start_edge = nxt_state.edge_out_pos;
               nxt_state.open_start_pos  = cur_state.last_turn_pos;
            end
         end else if (!above_hi && !below_lo) begin
            emit                 = 1'b1;
            nxt_state.in_bend    = 1'b0;
            nxt_state.bend_count = cur_state.bend_count + 8'd1;
         end else if (above_hi) begin
            if (cur_state.open_peak < sample.angle) begin
               nxt_state.open_peak = sample.angle;
            end
         end else begin
            if (cur_state.open_peak > sample.angle) begin
               nxt_state.open_peak = sample.angle;
            end
         end
         nxt_state.last_turn_pos = sample.position;
      end

      nxt_state.prev_falling      = falling;
      nxt_state.prev_angle        = sample.angle;
      nxt_state.prev_below_centre = below;
   end

   always_comb begin
      record.bend_index     = cur_state.bend_count;
      record.bend_kind      = cur_state.open_kind;
      record.peak_angle     = cur_state.open_peak;
      record.start_pos      = cur_state.open_start_pos;
      record.end_pos        = sample.position;
      record.start_edge_pos = cur_state.open_start_edge;
      record.end_edge_pos   = nxt_state.edge_in_pos;
   end

endmodule

@@ rtl/bend_segment_detector.sv @@
// bend_segment_detector: top level, turns steering samples into closed-bend records
// depends on bsd_pkg and bsd_step
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | req_type  (position, angle)
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_type  (one closed-bend record)
//  csr_    | in        | csr_valid/csr_ready | band_threshold, 7 bit
//
// one sample per cycle while req_stall is low; a record passes from its sample through the
// input register, then step logic into the result register
// reset: synchronous, active high; threshold returns to 10, tracking state clears
// a stalled result holds; the input register drains only when the result slot
// is free or being taken, so rsp_stall reaches req_stall in the same cycle
module bend_segment_detector
   import bsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);

   // configuration
   logic [6:0] threshold_ff;
   logic [6:0] threshold_in;

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   req_type    in_data_ff;

   // tracking state
   state_type  state_ff;
   state_type  state_in;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;

   state_type  step_state;
   logic       step_emit;
   rsp_type    step_record;

   logic       req_accept;
   logic       advance;

   // csr write is always taken; writes must come only while idle, not enforced
   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   // the held sample goes through whenever the result slot can take a record
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   bsd_step u_step (
      .cur_state      (state_ff),
      .sample         (in_data_ff),
      .band_threshold (threshold_ff),
      .nxt_state      (step_state),
      .emit           (step_emit),
      .record         (step_record)
   );

   assign state_in = advance ? step_state : state_ff;

   // new record replaces one taken in this cycle; otherwise hold while stalled
   always_comb begin
      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         in_valid_ff  <= 1'b0;
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance && step_emit) begin
         rsp_data_ff <= step_record;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/bsd_checker.sv @@
// bsd_checker: port-level assertions for bend_segment_detector, bound to the top level
// depends on bsd_pkg
module bsd_checker
   import bsd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic       seen_ff;
   logic       seen_in;
   logic [7:0] last_index_ff;
   logic [7:0] last_index_in;
   logic       rsp_accept;

   assign rsp_accept    = rsp_valid && !rsp_stall;
   assign seen_in       = rsp_accept ? 1'b1 : seen_ff;
   assign last_index_in = rsp_accept ? rsp_data.bend_index : last_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         last_index_ff <= 8'd0;
      end else begin
         seen_ff       <= seen_in;
         last_index_ff <= last_index_in;
      end
   end

   // a stalled record stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled record keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // records are numbered in sequence, first one after reset is zero
   a_index_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_accept |-> (seen_ff ? (rsp_data.bend_index == last_index_ff + 8'd1)
                              : (rsp_data.bend_index == 8'd0)))
      else $error("bend_index out of sequence");

   // nothing is offered right after a reset cycle
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind bend_segment_detector bsd_checker u_bsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
